@@ hw/rtl/jpp_pkg.sv @@
package jpp_pkg;

  localparam int LVL_W = 5;
  localparam int CNT_W = LVL_W + 1;
  localparam int Q_DEPTH = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0]       ch;
    logic             brk;
    logic [LVL_W-1:0] lvl;
    logic             tail_space;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NL,
    BK_SPACE,
    BK_CHAR,
    BK_TAIL
  } bk_state_t;

endpackage

@@ hw/rtl/jpp_front.sv @@
module jpp_front #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [7:0]                in_byte,
  output jpp_pkg::cmd_t             cmd,
  output logic [jpp_pkg::LVL_W-1:0] level
);

  localparam logic [jpp_pkg::LVL_W-1:0] MaxLvl = jpp_pkg::LVL_W'(MAX_DEPTH);

  logic                      in_str;
  logic                      esc;
  logic                      pend;
  logic                      in_str_next;
  logic                      esc_next;
  logic                      pend_next;
  logic [jpp_pkg::LVL_W-1:0] level_next;

  always_comb begin
    cmd.ch = in_byte;
    cmd.brk = 1'b0;
    cmd.lvl = level;
    cmd.tail_space = 1'b0;
    in_str_next = in_str;
    esc_next = esc;
    pend_next = pend;
    level_next = level;
    if (in_str) begin
      if (esc) begin
        esc_next = 1'b0;
      end else if (in_byte == jpp_pkg::CH_BSLASH) begin
        esc_next = 1'b1;
      end else if (in_byte == jpp_pkg::CH_QUOTE) begin
        in_str_next = 1'b0;
      end
    end else begin
      case (in_byte) inside
        jpp_pkg::CH_QUOTE: begin
          cmd.brk = pend;
          pend_next = 1'b0;
          in_str_next = 1'b1;
        end
        jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACK: begin
          cmd.brk = pend;
          pend_next = 1'b1;
          if (level < MaxLvl) begin
            level_next = level + 1'b1;
          end
        end
        jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACK: begin
          if (level != '0) begin
            level_next = level - 1'b1;
          end
          cmd.lvl = level_next;
          cmd.brk = !pend;
          pend_next = 1'b0;
        end
        jpp_pkg::CH_COMMA: begin
          pend_next = 1'b1;
        end
        jpp_pkg::CH_COLON: begin
          cmd.tail_space = 1'b1;
        end
        default: begin
          cmd.brk = pend;
          pend_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_str <= 1'b0;
      esc <= 1'b0;
      pend <= 1'b0;
      level <= '0;
    end else if (take) begin
      in_str <= in_str_next;
      esc <= esc_next;
      pend <= pend_next;
      level <= level_next;
    end
  end

endmodule

@@ hw/rtl/jpp_cmdq.sv @@
module jpp_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  jpp_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output jpp_pkg::cmd_t rd_cmd,
  output logic          empty
);

  localparam int PtrW = $clog2(jpp_pkg::Q_DEPTH);
  localparam int CntW = $clog2(jpp_pkg::Q_DEPTH + 1);

  jpp_pkg::cmd_t     mem [jpp_pkg::Q_DEPTH];
  logic [PtrW-1:0]   wptr;
  logic [PtrW-1:0]   rptr;
  logic [CntW-1:0]   count;

  assign full = count == CntW'(jpp_pkg::Q_DEPTH);
  assign empty = count == '0;
  assign rd_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CntW'(wr && !full) - CntW'(rd && !empty);
    end
  end

endmodule

@@ hw/rtl/jpp_back.sv @@
module jpp_back (
  input  logic          clk,
  input  logic          rst,
  input  jpp_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          run_last
);

  jpp_pkg::bk_state_t        st;
  jpp_pkg::bk_state_t        st_next;
  jpp_pkg::cmd_t             cur;
  jpp_pkg::cmd_t             cur_next;
  logic [jpp_pkg::CNT_W-1:0] cnt;
  logic [jpp_pkg::CNT_W-1:0] cnt_next;
  logic                      fire;

  always_comb begin
    st_next = st;
    cur_next = cur;
    cnt_next = cnt;
    out_byte = cur.ch;
    run_last = 1'b0;
    empty = st == jpp_pkg::BK_IDLE;
    fire = pop && !empty;
    case (st)
      jpp_pkg::BK_NL: begin
        out_byte = jpp_pkg::CH_NL;
        if (fire) begin
          cnt_next = {cur.lvl, 1'b0};
          st_next = (cur.lvl == '0) ? jpp_pkg::BK_CHAR : jpp_pkg::BK_SPACE;
        end
      end
      jpp_pkg::BK_SPACE: begin
        out_byte = jpp_pkg::CH_SPACE;
        if (fire) begin
          cnt_next = cnt - 1'b1;
          if (cnt == jpp_pkg::CNT_W'(1)) begin
            st_next = jpp_pkg::BK_CHAR;
          end
        end
      end
      jpp_pkg::BK_CHAR: begin
        out_byte = cur.ch;
        run_last = !cur.tail_space;
        if (fire) begin
          st_next = cur.tail_space ? jpp_pkg::BK_TAIL : jpp_pkg::BK_IDLE;
        end
      end
      jpp_pkg::BK_TAIL: begin
        out_byte = jpp_pkg::CH_SPACE;
        run_last = 1'b1;
        if (fire) begin
          st_next = jpp_pkg::BK_IDLE;
        end
      end
      default: begin
        st_next = jpp_pkg::BK_IDLE;
      end
    endcase
    q_pop = !q_empty && (empty || (fire && run_last));
    if (q_pop) begin
      cur_next = q_cmd;
      st_next = q_cmd.brk ? jpp_pkg::BK_NL : jpp_pkg::BK_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jpp_pkg::BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    cnt <= cnt_next;
  end

endmodule

@@ hw/rtl/json_pretty_print_stream.sv @@
// Streaming JSON pretty printer: compact JSON goes in one byte per push and
// indented text comes out one byte per pop, run_last marking the final byte
// produced by each input byte. The front end classifies each byte and keeps
// the string, escape, nesting and pending-newline state; it can take a byte
// every cycle while the two-entry command queue has room. The back end emits
// one output byte per cycle while pop is held and a byte is pending; an input
// byte produces one output byte for most bytes, two for a colon, and
// 2 + 2*level for a byte that starts a new line. Nesting saturates at 0 and MAX_DEPTH.
module json_pretty_print_stream #(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_last
);

  jpp_pkg::cmd_t             fr_cmd;
  jpp_pkg::cmd_t             q_cmd;
  logic [jpp_pkg::LVL_W-1:0] fr_level;
  logic                      q_empty;
  logic                      q_pop;
  logic                      take;

  assign take = push && !full;

  jpp_front #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .in_byte(in_byte),
    .cmd    (fr_cmd),
    .level  (fr_level)
  );

  jpp_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (take),
    .wr_cmd(fr_cmd),
    .full  (full),
    .rd    (q_pop),
    .rd_cmd(q_cmd),
    .empty (q_empty)
  );

  jpp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (q_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_byte(out_byte),
    .run_last(run_last)
  );

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    fr_level <= jpp_pkg::LVL_W'(MAX_DEPTH))
    else $error("nesting level above limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && empty) |=> !empty)
    else $error("back end idle with queued request");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    run_last |-> !empty)
    else $error("request end flagged with no output");

endmodule

@@ tb/tb_json_pretty_print_stream.sv @@
`timescale 1ns / 1ps

module tb_json_pretty_print_stream;

  localparam int MAX_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * MAX_DEPTH + 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } pretty_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] in_byte = 8'h00;
  wire        full;
  wire        empty;
  wire  [7:0] out_byte;
  wire        run_last;

  json_pretty_print_stream #(
    .MAX_DEPTH(MAX_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .run_last(run_last)
  );

  always #5 clk = ~clk;

  logic [7:0]   text_q[$];
  logic [7:0]   line_q[$];
  pretty_byte_t pretty_q[$];

  logic                      in_str;
  logic                      esc;
  logic [jpp_pkg::LVL_W-1:0] lvl;
  logic                      nl_owed;

  int errors = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  task automatic add_break;
    int i;
    line_q.push_back(jpp_pkg::CH_NL);
    for (i = 0; i < int'(lvl); i++) begin
      line_q.push_back(jpp_pkg::CH_SPACE);
      line_q.push_back(jpp_pkg::CH_SPACE);
    end
  endtask

  task automatic flush_owed;
    if (nl_owed) begin
      nl_owed = 1'b0;
      add_break();
    end
  endtask

  task automatic format_byte(input logic [7:0] c);
    int i;
    pretty_byte_t r;
    line_q.delete();
    if (in_str) begin
      line_q.push_back(c);
      if (esc) esc = 1'b0;
      else if (c == jpp_pkg::CH_BSLASH) esc = 1'b1;
      else if (c == jpp_pkg::CH_QUOTE) in_str = 1'b0;
    end else if (c == jpp_pkg::CH_QUOTE) begin
      flush_owed();
      line_q.push_back(c);
      in_str = 1'b1;
    end else if (c == jpp_pkg::CH_LBRACE || c == jpp_pkg::CH_LBRACK) begin
      flush_owed();
      line_q.push_back(c);
      if (int'(lvl) < MAX_DEPTH) lvl = lvl + 1'b1;
      nl_owed = 1'b1;
    end else if (c == jpp_pkg::CH_RBRACE || c == jpp_pkg::CH_RBRACK) begin
      if (lvl != '0) lvl = lvl - 1'b1;
      if (nl_owed) nl_owed = 1'b0;
      else add_break();
      line_q.push_back(c);
    end else if (c == jpp_pkg::CH_COMMA) begin
      line_q.push_back(c);
      nl_owed = 1'b1;
    end else if (c == jpp_pkg::CH_COLON) begin
      line_q.push_back(jpp_pkg::CH_COLON);
      line_q.push_back(jpp_pkg::CH_SPACE);
    end else begin
      flush_owed();
      line_q.push_back(c);
    end
    for (i = 0; i < line_q.size(); i++) begin
      r.ch = line_q[i];
      r.last = (i == line_q.size() - 1);
      pretty_q.push_back(r);
    end
  endtask

  task automatic push_b(input logic [7:0] b);
    text_q.push_back(b);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_b(8'(s[i]));
  endtask

  task automatic push_str;
    int n;
    int i;
    logic [7:0] b;
    push_b(jpp_pkg::CH_QUOTE);
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_b(jpp_pkg::CH_BSLASH);
        push_b(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 255));
        else b = 8'($urandom_range(32, 126));
        if (b == jpp_pkg::CH_QUOTE || b == jpp_pkg::CH_BSLASH) b = 8'h5f;
        push_b(b);
      end
    end
    push_b(jpp_pkg::CH_QUOTE);
  endtask

  task automatic push_scalar;
    int n;
    int i;
    case ($urandom_range(0, 3))
      0: push_str();
      1: begin
        if ($urandom_range(0, 1) == 0) push_b(8'h2d);
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) push_b(8'($urandom_range(0, 9) + 48));
      end
      2: begin
        if ($urandom_range(0, 1) == 0) push_text("true");
        else push_text("false");
      end
      default: push_text("null");
    endcase
  endtask

  // nesting past the saturation point, then closing past level zero
  task automatic deep_run;
    logic [7:0] stk[MAX_DEPTH+2];
    int i;
    for (i = 0; i < MAX_DEPTH + 2; i++) begin
      stk[i] = ($urandom_range(0, 1) == 0) ? jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACK;
      push_b(stk[i]);
    end
    push_scalar();
    for (i = MAX_DEPTH + 1; i >= 0; i--) begin
      push_b(stk[i] == jpp_pkg::CH_LBRACE ? jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACK);
    end
  endtask

  task automatic gen_doc;
    logic [7:0] stk[8];
    logic [7:0] b;
    int sp;
    int start;
    bit need_val;
    bit done;
    sp = 0;
    need_val = 1'b1;
    done = 1'b0;
    start = text_q.size();
    while (!done) begin
      if (need_val) begin
        if (sp < 6 && text_q.size() - start < 40 && $urandom_range(0, 99) < 40) begin
          b = ($urandom_range(0, 1) == 0) ? jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACK;
          push_b(b);
          stk[sp] = b;
          sp++;
          if ($urandom_range(0, 4) == 0) begin
            push_b(b == jpp_pkg::CH_LBRACE ? jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACK);
            sp--;
            need_val = 1'b0;
          end else if (b == jpp_pkg::CH_LBRACE) begin
            push_str();
            push_b(jpp_pkg::CH_COLON);
          end
        end else begin
          push_scalar();
          need_val = 1'b0;
        end
      end else if (sp == 0) begin
        done = 1'b1;
      end else if (text_q.size() - start < 40 && $urandom_range(0, 99) < 55) begin
        push_b(jpp_pkg::CH_COMMA);
        if (stk[sp-1] == jpp_pkg::CH_LBRACE) begin
          push_str();
          push_b(jpp_pkg::CH_COLON);
        end
        need_val = 1'b1;
      end else begin
        sp--;
        push_b(stk[sp] == jpp_pkg::CH_LBRACE ? jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACK);
      end
    end
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : sample
    pretty_byte_t e;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      // input request accepted
      if (push && !full) begin
        format_byte(in_byte);
        void'(text_q.pop_front());
        in_taken = 1'b1;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        out_taken = 1'b1;
        moved = 1'b1;
        if (pretty_q.size() == 0) begin
          $error("unexpected result: out_byte %02h run_last %0b", out_byte, run_last);
          errors++;
        end else begin
          e = pretty_q.pop_front();
          if (e.ch !== out_byte) begin
            $error("out_byte: expected %02h, got %02h", e.ch, out_byte);
            errors++;
          end
          if (e.last !== run_last) begin
            $error("run_last: expected %0b, got %0b", e.last, run_last);
            errors++;
          end
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_json_pretty_print_stream failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        if ($urandom_range(0, 19) == 0) calm_in = !calm_in;
        in_gap = pick_gap(calm_in);
      end
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (text_q.size() != 0) begin
        push <= 1'b1;
        in_byte <= text_q[0];
      end else begin
        push <= 1'b0;
      end

      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 19) == 0) calm_out = !calm_out;
        out_gap = pick_gap(calm_out);
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    int n;
    int i;
    logic [7:0] b;
    in_str = 1'b0;
    esc = 1'b0;
    lvl = '0;
    nl_owed = 1'b0;

    // closer at level zero, empty containers, byte extremes, escapes
    push_text("]{}[]");
    push_b(8'h00);
    push_b(8'hff);
    push_text(" {\"a\\\"b\":[1,x]}\n");

    deep_run();
    k = 0;
    while (text_q.size() < 230) begin
      k++;
      if (k == 15) deep_run();
      n = $urandom_range(0, 99);
      if (n < 70) begin
        gen_doc();
      end else if (n < 85) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == jpp_pkg::CH_QUOTE) b = 8'h27;
          push_b(b);
        end
      end else begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0: push_b(jpp_pkg::CH_LBRACE);
            1: push_b(jpp_pkg::CH_RBRACE);
            2: push_b(jpp_pkg::CH_LBRACK);
            3: push_b(jpp_pkg::CH_RBRACK);
            4: push_b(jpp_pkg::CH_COMMA);
            5: push_b(jpp_pkg::CH_COLON);
            6: push_b(jpp_pkg::CH_BSLASH);
            default: push_b(jpp_pkg::CH_SPACE);
          endcase
        end
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0 || pretty_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pretty_q.size() == 0) begin
      $display("tb_json_pretty_print_stream passed");
    end else begin
      $display("tb_json_pretty_print_stream failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/jpp_pkg.sv
hw/rtl/jpp_front.sv
hw/rtl/jpp_cmdq.sv
hw/rtl/jpp_back.sv
hw/rtl/json_pretty_print_stream.sv
tb/tb_json_pretty_print_stream.sv
